// ===== rtl/dtpy_pkg.sv =====
// dtpy_pkg: shared types, constants and helper functions for the pitch/yaw unit
// no dependencies; used by every module under rtl
package dtpy_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int IN_W  = 32;
    localparam int OUT_W = 25;
    localparam int ANG_W = 43;   // signed angle, 2^-32 degree units
    localparam int DP_W  = 64;   // cordic datapath width
    localparam int SH_W  = 6;
    localparam int PROD_W = 63;

    localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
    localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499207;
    localparam int NORM_MSB = 56;
    localparam int ALIGN_SH = 30;

    localparam logic signed [ANG_W-1:0] DEG_90  = 43'sd386547056640;
    localparam logic signed [ANG_W-1:0] DEG_180 = 43'sd773094113280;
    localparam logic signed [ANG_W-1:0] DEG_270 = 43'sd1159641169920;
    localparam logic signed [ANG_W-1:0] DEG_360 = 43'sd1546188226560;

    typedef struct packed {
        logic              zero_xy;
        logic              z_pos;
        logic              x_neg;
        logic              y_neg;
        logic [SH_W-1:0]   sh1;
        logic [PROD_W-1:0] prod;
        logic [OUT_W-1:0]  yaw;
    } side_t;

    // atan(2^-i) in 2^-32 degree units, alternating series, elaboration only
    function automatic logic signed [63:0] atan_step(input int i);
        logic [63:0]        d56;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int                 s;
        d56 = DEG_PER_RAD_Q32 << 24;
        sum = 64'sd0;
        if (i == 0)
            return 64'sd193273528320;
        for (int k = 0; k < 32; k++)
        begin
            s = i * (2 * k + 1);
            if (s < 63)
            begin
                term = signed'((d56 >> s) / 64'(2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return (sum + (64'sd1 <<< 23)) >>> 24;
    endfunction

    // index of the highest set bit, 0 for a zero word
    function automatic logic [SH_W-1:0] msb64(input logic [DP_W-1:0] v);
        logic [SH_W-1:0] p;
        p = '0;
        for (int i = 0; i < DP_W; i++)
        begin
            if (v[i])
                p = SH_W'(i);
        end
        return p;
    endfunction

    // map an angle onto [0,360) and round half up to 1/2^frac degree
    function automatic logic [OUT_W-1:0] to_output(input logic signed [ANG_W-1:0] acc,
                                                   input int frac);
        logic signed [ANG_W-1:0] a;
        logic [63:0]             r;
        logic [63:0]             full;
        a = acc;
        if (a < 0)
            a = a + DEG_360;
        r = (64'(unsigned'(a)) + (64'd1 << (31 - frac))) >> (32 - frac);
        full = 64'd360 << frac;
        if (r >= full)
            r = r - full;
        return r[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/dtpy_prep.sv =====
// dtpy_prep: magnitude, sign capture, z gain product and first normalization
// depends on dtpy_pkg
module dtpy_prep
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [dtpy_pkg::IN_W-1:0]  dir_x,
    input  logic signed [dtpy_pkg::IN_W-1:0]  dir_y,
    input  logic signed [dtpy_pkg::IN_W-1:0]  dir_z,
    output logic                              out_valid,
    output logic signed [dtpy_pkg::DP_W-1:0]  out_x,
    output logic signed [dtpy_pkg::DP_W-1:0]  out_y,
    output dtpy_pkg::side_t                   out_side
);

    logic                        a_valid_reg;
    logic [dtpy_pkg::IN_W-1:0]   ax_reg, ay_reg;
    dtpy_pkg::side_t             a_side_reg;
    logic [dtpy_pkg::IN_W-1:0]   ax_next, ay_next, az_next;
    dtpy_pkg::side_t             a_side_next;

    logic                        b_valid_reg;
    logic [dtpy_pkg::DP_W-1:0]   nx_reg, ny_reg;
    dtpy_pkg::side_t             b_side_reg;
    logic [dtpy_pkg::IN_W-1:0]   m;
    logic [dtpy_pkg::SH_W-1:0]   p;
    dtpy_pkg::side_t             b_side_next;

    // stage a: absolute values, flags and the gained |z| product
    always_comb
    begin
        ax_next = dir_x[dtpy_pkg::IN_W-1] ? (~dir_x + 1'b1) : dir_x;
        ay_next = dir_y[dtpy_pkg::IN_W-1] ? (~dir_y + 1'b1) : dir_y;
        az_next = dir_z[dtpy_pkg::IN_W-1] ? (~dir_z + 1'b1) : dir_z;
        a_side_next         = '0;
        a_side_next.zero_xy = (dir_x == '0) && (dir_y == '0);
        a_side_next.z_pos   = (dir_z > 0);
        a_side_next.x_neg   = dir_x[dtpy_pkg::IN_W-1];
        a_side_next.y_neg   = dir_y[dtpy_pkg::IN_W-1];
        a_side_next.prod    = dtpy_pkg::PROD_W'(az_next)
                              * dtpy_pkg::PROD_W'(dtpy_pkg::GAIN_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        a_side_reg <= a_side_next;
    end

    // stage b: shift the larger component to bit 56
    always_comb
    begin
        m = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        p = dtpy_pkg::msb64(dtpy_pkg::DP_W'(m));
        b_side_next     = a_side_reg;
        b_side_next.sh1 = dtpy_pkg::SH_W'(dtpy_pkg::NORM_MSB) - p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        nx_reg     <= dtpy_pkg::DP_W'(ax_reg) << b_side_next.sh1;
        ny_reg     <= dtpy_pkg::DP_W'(ay_reg) << b_side_next.sh1;
        b_side_reg <= b_side_next;
    end

    assign out_valid = b_valid_reg;
    assign out_x     = signed'(nx_reg);
    assign out_y     = signed'(ny_reg);
    assign out_side  = b_side_reg;

endmodule

// ===== rtl/dtpy_cordic.sv =====
// dtpy_cordic: unrolled cordic vectoring pipeline, one register stage per iteration
// depends on dtpy_pkg
module dtpy_cordic
#(
    parameter int STAGES = dtpy_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [dtpy_pkg::DP_W-1:0]   in_x,
    input  logic signed [dtpy_pkg::DP_W-1:0]   in_y,
    input  dtpy_pkg::side_t                    in_side,
    output logic                               out_valid,
    output logic signed [dtpy_pkg::ANG_W-1:0]  out_ang,
    output logic [dtpy_pkg::DP_W-1:0]          out_mag,
    output dtpy_pkg::side_t                    out_side
);

    logic                              valid_reg [STAGES+1];
    logic signed [dtpy_pkg::DP_W-1:0]  x_reg     [STAGES+1];
    logic signed [dtpy_pkg::DP_W-1:0]  y_reg     [STAGES+1];
    logic signed [dtpy_pkg::ANG_W-1:0] acc_reg   [STAGES+1];
    dtpy_pkg::side_t                   side_reg  [STAGES+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        x_reg[0]     = in_x;
        y_reg[0]     = in_y;
        acc_reg[0]   = '0;
        side_reg[0]  = in_side;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [dtpy_pkg::ANG_W-1:0] ATAN_I =
            dtpy_pkg::ANG_W'(dtpy_pkg::atan_step(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end

        // rotate toward the x axis, shifts round toward minus infinity
        always_ff @(posedge clk)
        begin
            if (y_reg[i] < 0)
            begin
                x_reg[i+1]   <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1]   <= y_reg[i] + (x_reg[i] >>> i);
                acc_reg[i+1] <= acc_reg[i] - ATAN_I;
            end
            else
            begin
                x_reg[i+1]   <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1]   <= y_reg[i] - (x_reg[i] >>> i);
                acc_reg[i+1] <= acc_reg[i] + ATAN_I;
            end
            side_reg[i+1] <= side_reg[i];
        end
    end

    // clamp to the first quadrant
    always_comb
    begin
        if (acc_reg[STAGES] < 0)
            out_ang = '0;
        else if (acc_reg[STAGES] > dtpy_pkg::DEG_90)
            out_ang = dtpy_pkg::DEG_90;
        else
            out_ang = acc_reg[STAGES];
        out_mag = (x_reg[STAGES] > 0) ? unsigned'(x_reg[STAGES]) : '0;
    end

    assign out_valid = valid_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

// ===== rtl/dtpy_mid.sv =====
// dtpy_mid: yaw quadrant mapping, pass two operand alignment and normalization
// depends on dtpy_pkg
module dtpy_mid
#(
    parameter int FRAC_BITS = dtpy_pkg::FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [dtpy_pkg::ANG_W-1:0]  in_ang,
    input  logic [dtpy_pkg::DP_W-1:0]          in_mag,
    input  dtpy_pkg::side_t                    in_side,
    output logic                               out_valid,
    output logic signed [dtpy_pkg::DP_W-1:0]   out_x,
    output logic signed [dtpy_pkg::DP_W-1:0]   out_y,
    output dtpy_pkg::side_t                    out_side
);

    logic                              c_valid_reg;
    logic [dtpy_pkg::DP_W-1:0]         x2_reg, y2_reg;
    dtpy_pkg::side_t                   c_side_reg;
    logic signed [dtpy_pkg::ANG_W-1:0] yaw_acc;
    logic [dtpy_pkg::DP_W-1:0]         x2_next, y2_next;
    dtpy_pkg::side_t                   c_side_next;

    logic                              d_valid_reg;
    logic [dtpy_pkg::DP_W-1:0]         nx_reg, ny_reg;
    dtpy_pkg::side_t                   d_side_reg;
    logic [dtpy_pkg::DP_W-1:0]         fx, m;
    logic [dtpy_pkg::SH_W-1:0]         p;
    logic [dtpy_pkg::DP_W-1:0]         nx_next, ny_next;

    // stage c: yaw result, bring magnitude and gained |z| to one scale
    always_comb
    begin
        if (!in_side.x_neg && !in_side.y_neg)
            yaw_acc = in_ang;
        else if (in_side.x_neg && !in_side.y_neg)
            yaw_acc = dtpy_pkg::DEG_180 - in_ang;
        else if (in_side.x_neg)
            yaw_acc = dtpy_pkg::DEG_180 + in_ang;
        else
            yaw_acc = dtpy_pkg::DEG_360 - in_ang;

        c_side_next      = in_side;
        c_side_next.yaw  = dtpy_pkg::to_output(yaw_acc, FRAC_BITS);
        c_side_next.prod = '0;
        c_side_next.sh1  = '0;

        x2_next = in_mag;
        y2_next = dtpy_pkg::DP_W'(in_side.prod);
        if (in_side.sh1 >= dtpy_pkg::SH_W'(dtpy_pkg::ALIGN_SH))
            x2_next = in_mag >> (in_side.sh1 - dtpy_pkg::SH_W'(dtpy_pkg::ALIGN_SH));
        else
            y2_next = dtpy_pkg::DP_W'(in_side.prod)
                      >> (dtpy_pkg::SH_W'(dtpy_pkg::ALIGN_SH) - in_side.sh1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        c_side_reg <= c_side_next;
    end

    // stage d: shared shift puts the larger operand at bit 56
    always_comb
    begin
        fx = ((x2_reg == '0) && (y2_reg == '0)) ? dtpy_pkg::DP_W'(1) : x2_reg;
        m  = (fx > y2_reg) ? fx : y2_reg;
        p  = dtpy_pkg::msb64(m);
        if (p > dtpy_pkg::SH_W'(dtpy_pkg::NORM_MSB))
        begin
            nx_next = fx     >> (p - dtpy_pkg::SH_W'(dtpy_pkg::NORM_MSB));
            ny_next = y2_reg >> (p - dtpy_pkg::SH_W'(dtpy_pkg::NORM_MSB));
        end
        else
        begin
            nx_next = fx     << (dtpy_pkg::SH_W'(dtpy_pkg::NORM_MSB) - p);
            ny_next = y2_reg << (dtpy_pkg::SH_W'(dtpy_pkg::NORM_MSB) - p);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        d_side_reg <= c_side_reg;
    end

    assign out_valid = d_valid_reg;
    assign out_x     = signed'(nx_reg);
    assign out_y     = signed'(ny_reg);
    assign out_side  = d_side_reg;

endmodule

// ===== rtl/direction_to_pitch_yaw_unit.sv =====
// direction_to_pitch_yaw_unit: top level, direction vector to pitch and yaw angles
// depends on dtpy_pkg, dtpy_prep, dtpy_cordic, dtpy_mid
//
//  channel   ports                        beat marked by
//  -------   --------------------------   ------------------------------
//  input     dir_x, dir_y, dir_z          start high while busy is low
//  result    pitch, yaw                   done high for one cycle
//
// one beat enters per cycle; busy never rises since the pipeline does not stall
// a beat passes two prep stages, two cordic passes of one stage per iteration,
// two stages between the passes and one output stage
// reset clears only the valid bits; payload registers carry no reset
// results cannot be held off by the receiver, so none is ever buffered
module direction_to_pitch_yaw_unit
#(
    parameter int FRAC_BITS     = dtpy_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = dtpy_pkg::CORDIC_STAGES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [dtpy_pkg::IN_W-1:0]  dir_x,
    input  logic signed [dtpy_pkg::IN_W-1:0]  dir_y,
    input  logic signed [dtpy_pkg::IN_W-1:0]  dir_z,
    output logic                              busy,
    output logic                              done,
    output logic [dtpy_pkg::OUT_W-1:0]        pitch,
    output logic [dtpy_pkg::OUT_W-1:0]        yaw
);

    // prep to pass one
    logic                              p_valid;
    logic signed [dtpy_pkg::DP_W-1:0]  p_x, p_y;
    dtpy_pkg::side_t                   p_side;
    // pass one to mid
    logic                              c1_valid;
    logic signed [dtpy_pkg::ANG_W-1:0] c1_ang;
    logic [dtpy_pkg::DP_W-1:0]         c1_mag;
    dtpy_pkg::side_t                   c1_side;
    // mid to pass two
    logic                              m_valid;
    logic signed [dtpy_pkg::DP_W-1:0]  m_x, m_y;
    dtpy_pkg::side_t                   m_side;
    // pass two out
    logic                              c2_valid;
    logic signed [dtpy_pkg::ANG_W-1:0] c2_ang;
    logic [dtpy_pkg::DP_W-1:0]         c2_mag;
    dtpy_pkg::side_t                   c2_side;

    logic                              done_reg;
    logic [dtpy_pkg::OUT_W-1:0]        pitch_reg, yaw_reg;
    logic signed [dtpy_pkg::ANG_W-1:0] pitch_acc;
    logic [dtpy_pkg::OUT_W-1:0]        pitch_next, yaw_next;
    logic                              unused_mag;

    // fully pipelined, never back-pressures the sender
    assign busy = 1'b0;

    dtpy_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .dir_x     (dir_x),
        .dir_y     (dir_y),
        .dir_z     (dir_z),
        .out_valid (p_valid),
        .out_x     (p_x),
        .out_y     (p_y),
        .out_side  (p_side)
    );

    // pass one: (|x|,|y|) gives first-quadrant yaw and the gained xy magnitude
    dtpy_cordic #(.STAGES(CORDIC_STAGES)) u_pass1
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid),
        .in_x      (p_x),
        .in_y      (p_y),
        .in_side   (p_side),
        .out_valid (c1_valid),
        .out_ang   (c1_ang),
        .out_mag   (c1_mag),
        .out_side  (c1_side)
    );

    dtpy_mid #(.FRAC_BITS(FRAC_BITS)) u_mid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_ang    (c1_ang),
        .in_mag    (c1_mag),
        .in_side   (c1_side),
        .out_valid (m_valid),
        .out_x     (m_x),
        .out_y     (m_y),
        .out_side  (m_side)
    );

    // pass two: gained magnitude against gained |z|, the gains cancel
    dtpy_cordic #(.STAGES(CORDIC_STAGES)) u_pass2
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .in_x      (m_x),
        .in_y      (m_y),
        .in_side   (m_side),
        .out_valid (c2_valid),
        .out_ang   (c2_ang),
        .out_mag   (c2_mag),
        .out_side  (c2_side)
    );

    // the second magnitude is not needed
    assign unused_mag = ^c2_mag;

    // pitch mapping, plus the vertical case where x and y are both zero
    always_comb
    begin
        pitch_acc  = c2_side.z_pos ? (dtpy_pkg::DEG_360 - c2_ang) : c2_ang;
        pitch_next = dtpy_pkg::to_output(pitch_acc, FRAC_BITS);
        yaw_next   = c2_side.yaw;
        if (c2_side.zero_xy)
        begin
            pitch_next = dtpy_pkg::to_output(c2_side.z_pos ? dtpy_pkg::DEG_270
                                                           : dtpy_pkg::DEG_90,
                                             FRAC_BITS);
            yaw_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c2_valid && !unused_mag | c2_valid;
    end

    always_ff @(posedge clk)
    begin
        pitch_reg <= pitch_next;
        yaw_reg   <= yaw_next;
    end

    assign done  = done_reg;
    assign pitch = pitch_reg;
    assign yaw   = yaw_reg;

endmodule

// ===== tb/sv/tb_direction_to_pitch_yaw_unit.sv =====
// tb_direction_to_pitch_yaw_unit: self-checking testbench for the pitch/yaw unit
// depends on dtpy_pkg and rtl/direction_to_pitch_yaw_unit.sv
// directed table first, then random vectors checked against a local cordic predictor
`timescale 1ns / 100ps

module tb_direction_to_pitch_yaw_unit;

    localparam int FRAC      = 16;
    localparam int STAGES    = 24;
    localparam int LATENCY   = 2 * STAGES + 5;
    localparam int N_RANDOM  = 500;
    localparam int MAX_CYCLE = 200000;

    localparam logic signed [63:0] ONE_DEG   = 64'sd4294967296;
    localparam logic [63:0]        RAD_Q32   = 64'd246083499207;
    localparam logic [63:0]        GAIN_LIM  = 64'd1768195363;
    localparam logic [24:0]        ANGLE_90  = 25'd5898240;
    localparam logic [24:0]        ANGLE_270 = 25'd17694720;
    localparam logic [24:0]        NO_CHECK  = 25'h1FFFFFF;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic signed [dtpy_pkg::IN_W-1:0]  dir_x;
    logic signed [dtpy_pkg::IN_W-1:0]  dir_y;
    logic signed [dtpy_pkg::IN_W-1:0]  dir_z;
    logic                              busy;
    logic                              done;
    logic [dtpy_pkg::OUT_W-1:0]        pitch;
    logic [dtpy_pkg::OUT_W-1:0]        yaw;

    typedef struct {
        logic [24:0] pitch;
        logic [24:0] yaw;
    } angles_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [24:0]        pitch;   // NO_CHECK means use the predictor
        logic [24:0]        yaw;
    } vec_row_t;

    angles_t            pending_angles[$];
    logic signed [63:0] atan_lut[STAGES];
    int                 n_errors;
    int                 cycle_cnt;
    int                 send_idle_pct;

    direction_to_pitch_yaw_unit
    #(
        .FRAC_BITS     (FRAC),
        .CORDIC_STAGES (STAGES)
    )
    i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dir_x (dir_x),
        .dir_y (dir_y),
        .dir_z (dir_z),
        .busy  (busy),
        .done  (done),
        .pitch (pitch),
        .yaw   (yaw)
    );

    // 10 ns clock, high then low
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor shift for signed values
    function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    // atan(2^-i) in 2^-32 degree, alternating series in integers
    function automatic logic signed [63:0] arctan_entry(int i);
        logic [63:0]        d56;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int                 s;
        d56 = RAD_Q32 << 24;
        sum = 0;
        if (i == 0)
            return 45 * ONE_DEG;
        for (int k = 0; k < 64; k++)
        begin
            s = i * (2 * k + 1);
            if (s >= 63)
                break;
            term = signed'((d56 >> s) / 64'(2 * k + 1));
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        return (sum + (64'sd1 <<< 23)) >>> 24;
    endfunction

    // vectoring pass on nonnegative pair, angle clamped to [0,90] degrees
    function automatic logic signed [63:0] cordic_angle(logic [63:0] x_in, logic [63:0] y_in,
                                                        output logic [63:0] mag);
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] acc;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        xs = signed'(x_in);
        ys = signed'(y_in);
        acc = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = floor_shr(ys, i);
            dy = floor_shr(xs, i);
            if (ys < 0)
            begin
                xs = xs - dx;
                ys = ys + dy;
                acc = acc - atan_lut[i];
            end
            else
            begin
                xs = xs + dx;
                ys = ys - dy;
                acc = acc + atan_lut[i];
            end
        end
        mag = (xs > 0) ? unsigned'(xs) : 64'd0;
        if (acc < 0)
            acc = 0;
        if (acc > 90 * ONE_DEG)
            acc = 90 * ONE_DEG;
        return acc;
    endfunction

    // wrap into [0,360) and round half up to the output grid
    function automatic logic [24:0] angle_code(logic signed [63:0] acc);
        logic [63:0] r;
        logic [63:0] full;
        full = 64'd360 << FRAC;
        if (acc < 0)
            acc = acc + 360 * ONE_DEG;
        r = (unsigned'(acc) + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
        if (r >= full)
            r = r - full;
        return r[24:0];
    endfunction

    function automatic angles_t predict_angles(logic signed [31:0] x, logic signed [31:0] y,
                                               logic signed [31:0] z);
        angles_t            res;
        logic [63:0]        ax;
        logic [63:0]        ay;
        logic [63:0]        az;
        logic [63:0]        m;
        logic [63:0]        mag;
        logic [63:0]        unused_mag;
        logic [63:0]        x2;
        logic [63:0]        y2;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] yaw_acc;
        int                 sh1;
        if (x == 0 && y == 0)
        begin
            res.pitch = angle_code((z > 0 ? 270 : 90) * ONE_DEG);
            res.yaw = 0;
            return res;
        end
        ax = (x < 0) ? 64'(-64'sd1 * x) : 64'(x);
        ay = (y < 0) ? 64'(-64'sd1 * y) : 64'(y);
        az = (z < 0) ? 64'(-64'sd1 * z) : 64'(z);
        m = (ax > ay) ? ax : ay;
        sh1 = 0;
        while (m < (64'd1 << 56))
        begin
            ax = ax << 1;
            ay = ay << 1;
            m = m << 1;
            sh1++;
        end
        a = cordic_angle(ax, ay, mag);
        if (x >= 0 && y >= 0)
            yaw_acc = a;
        else if (x < 0 && y >= 0)
            yaw_acc = 180 * ONE_DEG - a;
        else if (x < 0)
            yaw_acc = 180 * ONE_DEG + a;
        else
            yaw_acc = 360 * ONE_DEG - a;
        // bring magnitude and gained |z| onto one scale
        x2 = mag;
        y2 = az * GAIN_LIM;
        if (sh1 >= 30)
            x2 = x2 >> (sh1 - 30);
        else
            y2 = y2 >> (30 - sh1);
        if (x2 == 0 && y2 == 0)
            x2 = 1;
        m = (x2 > y2) ? x2 : y2;
        while (m >= (64'd1 << 57))
        begin
            x2 = x2 >> 1;
            y2 = y2 >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << 56))
        begin
            x2 = x2 << 1;
            y2 = y2 << 1;
            m = m << 1;
        end
        b = cordic_angle(x2, y2, unused_mag);
        res.pitch = angle_code((z > 0) ? 360 * ONE_DEG - b : b);
        res.yaw = angle_code(yaw_acc);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [24:0] got, logic [24:0] want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
        n_errors++;
    endtask

    // one beat: idle for a random number of cycles, then present the vector
    // start stays high on return so beats can follow back to back
    task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, angles_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_angles.push_back(want);
    endtask

    // result side: the strobe marks the one cycle a beat is valid
    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && done)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_cnt);
                n_errors++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (pitch !== want.pitch)
                    report_mismatch("pitch", pitch, want.pitch);
                if (yaw !== want.yaw)
                    report_mismatch("yaw", yaw, want.yaw);
            end
        end
    end

    // watchdog on a free-running cycle count
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLE)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(7))
            0: return 32'sh80000000;
            1: return 32'sh7FFFFFFF;
            2: return 0;
            3: return signed'(32'($urandom_range(255)) - 32'd128);
            default: return signed'($urandom);
        endcase
    endfunction

    initial
    begin
        vec_row_t directed[$];
        angles_t  want;
        int       n_sent;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        n_errors = 0;
        cycle_cnt = 0;
        send_idle_pct = 25;
        rst_n = 1'b0;
        start = 1'b0;
        dir_x = 0;
        dir_y = 0;
        dir_z = 0;
        for (int i = 0; i < STAGES; i++)
            atan_lut[i] = arctan_entry(i);

        // zero x and y: yaw 0, pitch 270 for positive z, else 90
        directed.push_back('{0, 0, 0, ANGLE_90, 0});
        directed.push_back('{0, 0, 65536, ANGLE_270, 0});
        directed.push_back('{0, 0, -65536, ANGLE_90, 0});
        directed.push_back('{0, 0, 32'sh7FFFFFFF, ANGLE_270, 0});
        directed.push_back('{0, 0, 32'sh80000000, ANGLE_90, 0});
        // axes and quadrants, extremes, wrap near 360
        directed.push_back('{65536, 0, 0, NO_CHECK, NO_CHECK});
        directed.push_back('{-65536, 0, 0, NO_CHECK, NO_CHECK});
        directed.push_back('{0, 65536, 0, NO_CHECK, NO_CHECK});
        directed.push_back('{0, -65536, 0, NO_CHECK, NO_CHECK});
        directed.push_back('{1, 1, 1, NO_CHECK, NO_CHECK});
        directed.push_back('{-1, 1, -1, NO_CHECK, NO_CHECK});
        directed.push_back('{-1, -1, 1, NO_CHECK, NO_CHECK});
        directed.push_back('{1, -1, -1, NO_CHECK, NO_CHECK});
        directed.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, NO_CHECK, NO_CHECK});
        directed.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, NO_CHECK, NO_CHECK});
        directed.push_back('{32'sh80000000, 0, 32'sh7FFFFFFF, NO_CHECK, NO_CHECK});
        directed.push_back('{32'sh7FFFFFFF, -1, 0, NO_CHECK, NO_CHECK});
        directed.push_back('{32'sh7FFFFFFF, 1, 1, NO_CHECK, NO_CHECK});
        directed.push_back('{1, 0, 32'sh80000000, NO_CHECK, NO_CHECK});
        directed.push_back('{1, 0, 32'sh7FFFFFFF, NO_CHECK, NO_CHECK});
        directed.push_back('{-32'sd5, 32'sd0, 32'sd0, NO_CHECK, NO_CHECK});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            want = predict_angles(directed[i].x, directed[i].y, directed[i].z);
            if (directed[i].pitch != NO_CHECK)
            begin
                want.pitch = directed[i].pitch;
                want.yaw = directed[i].yaw;
            end
            send_vector(directed[i].x, directed[i].y, directed[i].z, want);
        end

        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);

        // three idling phases for the sender: 25 percent idle, then 83 percent, then none
        for (n_sent = 0; n_sent < N_RANDOM; n_sent++)
        begin
            if (n_sent == N_RANDOM / 3)
                send_idle_pct = 83;
            else if (n_sent == 2 * N_RANDOM / 3)
                send_idle_pct = 0;
            rx = rand_comp();
            ry = rand_comp();
            rz = rand_comp();
            send_vector(rx, ry, rz, predict_angles(rx, ry, rz));
        end

        start <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
